[src/consensus_log_term_table_assert.svh]
// Assertion macros used by the term table controller RTL.
`ifndef CONSENSUS_LOG_TERM_TABLE_ASSERT_SVH
`define CONSENSUS_LOG_TERM_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("consensus_log_term_table: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("consensus_log_term_table: check failed");

`endif

[src/clt_pkg.sv]
`default_nettype none

package clt_pkg;

  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [2:0] {
    CMD_APPEND    = 3'd0,
    CMD_REPLICATE = 3'd1,
    CMD_LOOKUP    = 3'd2,
    CMD_TRUNCATE  = 3'd3,
    CMD_VOTE      = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_DONE      = 3'd0,
    STAT_NO_CHANGE = 3'd1,
    STAT_CONFLICT  = 3'd2,
    STAT_IN_SNAP   = 3'd3,
    STAT_GAP       = 3'd4,
    STAT_FULL      = 3'd5
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SNAP_INDEX = 2'd0,
    CFG_SNAP_TERM  = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEC,
    S_CMP,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [31:0] snap_index;
    logic [31:0] snap_term;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] index_out;
    logic [31:0] term_out;
    logic        ours_newer;
    logic [31:0] last_index;
    logic [31:0] last_term;
  } res_t;

endpackage

`default_nettype wire

[src/clt_ram.sv]
`default_nettype none

module clt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

[src/clt_ctrl.sv]
`default_nettype none
`include "consensus_log_term_table_assert.svh"

module clt_ctrl #(
  parameter int unsigned LOG_DEPTH = 1024
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [2:0]        cmd_i,
  input  wire logic [31:0]       term_in_i,
  input  wire logic [31:0]       index_in_i,
  input  wire clt_pkg::cfg_t     cfg_i,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output clt_pkg::res_t          res_o
);

  localparam int unsigned AW = $clog2(LOG_DEPTH);
  localparam int unsigned CW = $clog2(LOG_DEPTH + 1);

  clt_pkg::state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic [31:0]   tail_q, tail_d;
  logic [2:0]    cmd_q;
  logic [31:0]   term_q;
  logic [31:0]   idx_q;
  logic [AW-1:0] slot_q, slot_d;
  logic [2:0]    status_q, status_d;
  logic [31:0]   index_out_q, index_out_d;
  logic [31:0]   term_out_q, term_out_d;
  logic          newer_q, newer_d;
  logic          need_read;

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_rdata;

  logic [32:0]   end_idx;
  logic [32:0]   app_idx;
  logic [31:0]   slot_full;
  logic [31:0]   cnt32;
  logic          in_snap, slot_lt, slot_eq, full;
  logic [31:0]   my_term;

  clt_ram #(
    .WIDTH (32),
    .DEPTH (LOG_DEPTH)
  ) u_term_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (term_q),
    .rdata_o (mem_rdata)
  );

  // Position of the requested index relative to the snapshot and the log end.
  always_comb begin
    cnt32     = {{(32 - CW){1'b0}}, count_q};
    end_idx   = {1'b0, cfg_i.snap_index} + {1'b0, cnt32};
    app_idx   = end_idx + 33'd1;
    slot_full = idx_q - cfg_i.snap_index - 32'd1;
    in_snap   = idx_q <= cfg_i.snap_index;
    slot_lt   = slot_full < cnt32;
    slot_eq   = slot_full == cnt32;
    full      = count_q == CW'(LOG_DEPTH);
    my_term   = (count_q == '0) ? cfg_i.snap_term : tail_q;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      clt_pkg::S_IDLE: if (in_valid_i) state_d = clt_pkg::S_DEC;
      clt_pkg::S_DEC:  state_d = need_read ? clt_pkg::S_CMP : clt_pkg::S_FIN;
      clt_pkg::S_CMP:  state_d = clt_pkg::S_FIN;
      clt_pkg::S_FIN:  if (res_ready_i) state_d = clt_pkg::S_IDLE;
      default:         state_d = clt_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    count_d     = count_q;
    tail_d      = tail_q;
    slot_d      = slot_q;
    status_d    = status_q;
    index_out_d = index_out_q;
    term_out_d  = term_out_q;
    newer_d     = newer_q;
    need_read   = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = slot_full[AW-1:0];

    unique case (state_q)
      clt_pkg::S_DEC: begin
        index_out_d = '0;
        term_out_d  = '0;
        newer_d     = 1'b0;
        slot_d      = slot_full[AW-1:0];
        status_d    = clt_pkg::STAT_NO_CHANGE;
        unique case (cmd_q)
          clt_pkg::CMD_APPEND: begin
            if (full || app_idx[32]) begin
              status_d = clt_pkg::STAT_FULL;
            end else begin
              mem_we      = 1'b1;
              mem_addr    = count_q[AW-1:0];
              count_d     = count_q + CW'(1);
              tail_d      = term_q;
              index_out_d = app_idx[31:0];
              status_d    = clt_pkg::STAT_DONE;
            end
          end
          clt_pkg::CMD_REPLICATE: begin
            if (in_snap) begin
              status_d = clt_pkg::STAT_IN_SNAP;
            end else if (slot_lt) begin
              need_read = 1'b1;
            end else if (slot_eq) begin
              if (full) begin
                status_d = clt_pkg::STAT_FULL;
              end else begin
                mem_we   = 1'b1;
                mem_addr = count_q[AW-1:0];
                count_d  = count_q + CW'(1);
                tail_d   = term_q;
                status_d = clt_pkg::STAT_DONE;
              end
            end else begin
              status_d = clt_pkg::STAT_GAP;
            end
          end
          clt_pkg::CMD_LOOKUP: begin
            status_d = clt_pkg::STAT_DONE;
            if (idx_q == '0) begin
              term_out_d = '0;
            end else if (idx_q == cfg_i.snap_index) begin
              term_out_d = cfg_i.snap_term;
            end else if (idx_q < cfg_i.snap_index || {1'b0, idx_q} > end_idx) begin
              term_out_d = '0;
            end else begin
              need_read = 1'b1;
            end
          end
          clt_pkg::CMD_TRUNCATE: begin
            if (in_snap) begin
              status_d = clt_pkg::STAT_IN_SNAP;
            end else if (slot_lt) begin
              status_d = clt_pkg::STAT_DONE;
              count_d  = CW'(slot_full[AW-1:0]);
              // The new tail term sits one slot below the cut.
              if (slot_full[AW-1:0] != '0) begin
                need_read = 1'b1;
                mem_addr  = slot_full[AW-1:0] - AW'(1);
              end
            end else begin
              status_d = clt_pkg::STAT_NO_CHANGE;
            end
          end
          clt_pkg::CMD_VOTE: begin
            status_d = clt_pkg::STAT_DONE;
            if (my_term != term_q) begin
              newer_d = my_term > term_q;
            end else begin
              newer_d = end_idx > {1'b0, idx_q};
            end
          end
          default: status_d = clt_pkg::STAT_NO_CHANGE;
        endcase
      end
      clt_pkg::S_CMP: begin
        mem_addr = slot_q;
        case (cmd_q)
          clt_pkg::CMD_REPLICATE: begin
            if (mem_rdata == term_q) begin
              status_d = clt_pkg::STAT_NO_CHANGE;
            end else begin
              mem_we   = 1'b1;
              count_d  = CW'(slot_q) + CW'(1);
              tail_d   = term_q;
              status_d = clt_pkg::STAT_CONFLICT;
            end
          end
          clt_pkg::CMD_LOOKUP:   term_out_d = mem_rdata;
          clt_pkg::CMD_TRUNCATE: tail_d = mem_rdata;
          default:               status_d = status_q;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    in_ready_o         = state_q == clt_pkg::S_IDLE;
    res_valid_o        = state_q == clt_pkg::S_FIN;
    res_o.status       = status_q;
    res_o.index_out    = index_out_q;
    res_o.term_out     = term_out_q;
    res_o.ours_newer   = newer_q;
    res_o.last_index   = end_idx[32] ? 32'hFFFF_FFFF : end_idx[31:0];
    res_o.last_term    = my_term;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= clt_pkg::S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q  <= cmd_i;
      term_q <= term_in_i;
      idx_q  <= index_in_i;
    end
    tail_q      <= tail_d;
    slot_q      <= slot_d;
    status_q    <= status_d;
    index_out_q <= index_out_d;
    term_out_q  <= term_out_d;
    newer_q     <= newer_d;
  end

  `CLT_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CW'(LOG_DEPTH))
  `CLT_ASSERT_IMPL(a_we_state, clk_i, rst_ni, mem_we, state_q == clt_pkg::S_DEC || state_q == clt_pkg::S_CMP)
  `CLT_ASSERT_NEXT(a_accept_dec, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == clt_pkg::S_DEC)
  `CLT_ASSERT_NEXT(a_we_count, clk_i, rst_ni, mem_we, count_q == CW'($past(mem_addr)) + CW'(1))

endmodule

`default_nettype wire

[src/consensus_log_term_table.sv]
// A result passes from the decode state to the result state and then the output register.
// A replicated entry that meets an existing slot, an in-range lookup and a truncation that
// keeps entries also read the single-port term memory and pass through the compare state.
// A new command is taken only in idle; the output register frees the input side while a
// result waits. Reset clears the entry count, the snapshot registers and all control; the
// term memory holds no reset and needs no clearing pass.
`default_nettype none

module consensus_log_term_table #(
  parameter int unsigned LOG_DEPTH = 1024
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [2:0]                  cmd_i,
  input  wire logic [31:0]                 term_in_i,
  input  wire logic [31:0]                 index_in_i,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [clt_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]                 cfg_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [2:0]                       status_o,
  output logic [31:0]                      index_out_o,
  output logic [31:0]                      term_out_o,
  output logic                             ours_newer_o,
  output logic [31:0]                      last_index_o,
  output logic [31:0]                      last_term_o
);

  clt_pkg::cfg_t cfg_q;
  clt_pkg::res_t res, out_q;
  logic          res_valid, res_ready;
  logic          out_valid_q;

  assign cfg_ready_o = 1'b1;
  assign res_ready   = !out_valid_q || out_ready_i;

  clt_ctrl #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .term_in_i   (term_in_i),
    .index_in_i  (index_in_i),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          clt_pkg::CFG_SNAP_INDEX: cfg_q.snap_index <= cfg_data_i;
          clt_pkg::CFG_SNAP_TERM:  cfg_q.snap_term  <= cfg_data_i;
          default: ;
        endcase
      end
      if (res_ready) begin
        out_valid_q <= res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_q.status;
  assign index_out_o  = out_q.index_out;
  assign term_out_o   = out_q.term_out;
  assign ours_newer_o = out_q.ours_newer;
  assign last_index_o = out_q.last_index;
  assign last_term_o  = out_q.last_term;

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned LOG_DEPTH   = 1024;
  localparam int unsigned CYCLE_LIMIT = 600_000;
  // Command codes that the block does not define; it must report no change for them.
  localparam logic [2:0]  CMD_FIRST_BAD = 3'd5;
  localparam logic [2:0]  CMD_LAST_BAD  = 3'd7;

  typedef struct {
    logic [2:0]    op;
    logic [31:0]   term;
    logic [31:0]   idx;
    bit            typed;
    clt_pkg::res_t want;
  } dir_step_t;

  logic                         clk_i        = 1'b0;
  logic                         rst_ni       = 1'b0;
  logic                         in_valid_i   = 1'b0;
  logic [2:0]                   cmd_i        = '0;
  logic [31:0]                  term_in_i    = '0;
  logic [31:0]                  index_in_i   = '0;
  logic                         cfg_valid_i  = 1'b0;
  logic [clt_pkg::CfgIdxW-1:0]  cfg_index_i  = '0;
  logic [31:0]                  cfg_data_i   = '0;
  logic                         out_ready_i  = 1'b0;
  logic                         in_ready_o;
  logic                         cfg_ready_o;
  logic                         out_valid_o;
  logic [2:0]                   status_o;
  logic [31:0]                  index_out_o;
  logic [31:0]                  term_out_o;
  logic                         ours_newer_o;
  logic [31:0]                  last_index_o;
  logic [31:0]                  last_term_o;

  // Mirror of the term table and its snapshot registers.
  logic [31:0] term_mem [LOG_DEPTH];
  int unsigned n_entries   = 0;
  logic [31:0] snap_index_q = '0;
  logic [31:0] snap_term_q  = '0;

  clt_pkg::res_t due_replies [$];
  int unsigned   n_errors    = 0;
  int unsigned   cycle_count = 0;
  int unsigned   idle_odds   = 4;
  bit            no_idle     = 1'b0;

  // Starts from the reset state: snapshot index and term both zero, log empty.
  dir_step_t dir_rows [25] = '{
    '{clt_pkg::CMD_LOOKUP,    32'hFFFF_FFFF, 32'd0,         1'b1,
      '{clt_pkg::STAT_DONE, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0}},
    '{CMD_LAST_BAD,           32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      '{clt_pkg::STAT_NO_CHANGE, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0}},
    '{clt_pkg::CMD_REPLICATE, 32'd3,         32'd0,         1'b1,
      '{clt_pkg::STAT_IN_SNAP, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0}},
    '{clt_pkg::CMD_TRUNCATE,  32'd0,         32'd0,         1'b1,
      '{clt_pkg::STAT_IN_SNAP, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0}},
    '{clt_pkg::CMD_VOTE,      32'd0,         32'd0,         1'b1,
      '{clt_pkg::STAT_DONE, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0}},
    '{clt_pkg::CMD_APPEND,    32'hFFFF_FFFF, 32'd0,         1'b1,
      '{clt_pkg::STAT_DONE, 32'd1, 32'd0, 1'b0, 32'd1, 32'hFFFF_FFFF}},
    '{clt_pkg::CMD_VOTE,      32'hFFFF_FFFF, 32'd0,         1'b0, '0},
    '{clt_pkg::CMD_APPEND,    32'd0,         32'hFFFF_FFFF, 1'b0, '0},
    '{clt_pkg::CMD_APPEND,    32'd2,         32'd0,         1'b0, '0},
    '{clt_pkg::CMD_REPLICATE, 32'hFFFF_FFFF, 32'd1,         1'b0, '0},
    '{clt_pkg::CMD_REPLICATE, 32'd7,         32'd2,         1'b0, '0},
    '{clt_pkg::CMD_REPLICATE, 32'd7,         32'd3,         1'b0, '0},
    '{clt_pkg::CMD_REPLICATE, 32'd8,         32'd5,         1'b0, '0},
    '{clt_pkg::CMD_REPLICATE, 32'd1,         32'hFFFF_FFFF, 1'b0, '0},
    '{clt_pkg::CMD_LOOKUP,    32'd0,         32'd2,         1'b0, '0},
    '{clt_pkg::CMD_LOOKUP,    32'd0,         32'd3,         1'b0, '0},
    '{clt_pkg::CMD_LOOKUP,    32'd0,         32'd4,         1'b0, '0},
    '{clt_pkg::CMD_LOOKUP,    32'd0,         32'hFFFF_FFFF, 1'b0, '0},
    '{clt_pkg::CMD_TRUNCATE,  32'd0,         32'd4,         1'b0, '0},
    '{clt_pkg::CMD_TRUNCATE,  32'd0,         32'd3,         1'b0, '0},
    '{clt_pkg::CMD_VOTE,      32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
    '{clt_pkg::CMD_VOTE,      32'd7,         32'd1,         1'b0, '0},
    '{clt_pkg::CMD_VOTE,      32'd0,         32'hFFFF_FFFF, 1'b0, '0},
    '{CMD_FIRST_BAD,          32'd0,         32'd0,         1'b0, '0},
    '{clt_pkg::CMD_TRUNCATE,  32'd0,         32'd1,         1'b0, '0}
  };

  consensus_log_term_table #(
    .LOG_DEPTH(LOG_DEPTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .term_in_i    (term_in_i),
    .index_in_i   (index_in_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .index_out_o  (index_out_o),
    .term_out_o   (term_out_o),
    .ours_newer_o (ours_newer_o),
    .last_index_o (last_index_o),
    .last_term_o  (last_term_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [31:0] log_tail_term();
    if (n_entries == 0) return snap_term_q;
    return term_mem[n_entries - 1];
  endfunction

  // Applies one command to the mirrored table and returns the reply it must produce.
  function automatic clt_pkg::res_t table_step(input logic [2:0] op, input logic [31:0] term,
                                               input logic [31:0] idx);
    clt_pkg::res_t r;
    logic [32:0]   end_ix;
    logic [31:0]   slot;
    logic [31:0]   mine;
    r = '0;
    r.status = clt_pkg::STAT_NO_CHANGE;
    end_ix = {1'b0, snap_index_q} + 33'(n_entries);
    slot = idx - snap_index_q - 32'd1;
    case (op)
      clt_pkg::CMD_APPEND: begin
        if (n_entries >= LOG_DEPTH || end_ix + 33'd1 > 33'h0_FFFF_FFFF) begin
          r.status = clt_pkg::STAT_FULL;
        end else begin
          term_mem[n_entries] = term;
          n_entries++;
          r.index_out = end_ix[31:0] + 32'd1;
          r.status = clt_pkg::STAT_DONE;
        end
      end
      clt_pkg::CMD_REPLICATE: begin
        if (idx <= snap_index_q) begin
          r.status = clt_pkg::STAT_IN_SNAP;
        end else if (slot < n_entries) begin
          if (term_mem[slot] == term) begin
            r.status = clt_pkg::STAT_NO_CHANGE;
          end else begin
            // A conflicting term cuts the log back to this entry.
            term_mem[slot] = term;
            n_entries = slot + 1;
            r.status = clt_pkg::STAT_CONFLICT;
          end
        end else if (slot == n_entries) begin
          if (n_entries >= LOG_DEPTH) begin
            r.status = clt_pkg::STAT_FULL;
          end else begin
            term_mem[slot] = term;
            n_entries++;
            r.status = clt_pkg::STAT_DONE;
          end
        end else begin
          r.status = clt_pkg::STAT_GAP;
        end
      end
      clt_pkg::CMD_LOOKUP: begin
        r.status = clt_pkg::STAT_DONE;
        if (idx == '0) begin
          r.term_out = '0;
        end else if (idx == snap_index_q) begin
          r.term_out = snap_term_q;
        end else if (idx < snap_index_q || {1'b0, idx} > end_ix) begin
          r.term_out = '0;
        end else begin
          r.term_out = term_mem[slot];
        end
      end
      clt_pkg::CMD_TRUNCATE: begin
        if (idx <= snap_index_q) begin
          r.status = clt_pkg::STAT_IN_SNAP;
        end else if (slot < n_entries) begin
          n_entries = slot;
          r.status = clt_pkg::STAT_DONE;
        end else begin
          r.status = clt_pkg::STAT_NO_CHANGE;
        end
      end
      clt_pkg::CMD_VOTE: begin
        mine = log_tail_term();
        r.status = clt_pkg::STAT_DONE;
        if (mine != term) r.ours_newer = (mine > term);
        else r.ours_newer = (end_ix > {1'b0, idx});
      end
      default: ;
    endcase
    end_ix = {1'b0, snap_index_q} + 33'(n_entries);
    r.last_index = end_ix[32] ? 32'hFFFF_FFFF : end_ix[31:0];
    r.last_term = log_tail_term();
    return r;
  endfunction

  // Most indexes land around the live part of the log, so that replication, lookups and
  // truncation mostly meet stored entries; terms often repeat the stored one.
  task automatic pick_item(input bit filling, output logic [2:0] op,
                           output logic [31:0] term, output logic [31:0] idx);
    int unsigned r;
    logic [31:0] slot;
    r = $urandom_range(0, 99);
    term = $urandom_range(0, 7);
    idx = snap_index_q + 32'd1 + $urandom_range(0, n_entries + 1);
    if (filling) begin
      if (r < 88) begin
        op = clt_pkg::CMD_APPEND;
      end else if (r < 94) begin
        op = clt_pkg::CMD_LOOKUP;
      end else begin
        op = clt_pkg::CMD_REPLICATE;
        idx = snap_index_q + n_entries + 32'd1;
      end
    end else begin
      if (r < 22) begin
        op = clt_pkg::CMD_APPEND;
      end else if (r < 50) begin
        op = clt_pkg::CMD_REPLICATE;
      end else if (r < 70) begin
        op = clt_pkg::CMD_LOOKUP;
      end else if (r < 78) begin
        op = clt_pkg::CMD_TRUNCATE;
        idx = snap_index_q + n_entries + 32'd1 - $urandom_range(0, 3);
      end else if (r < 94) begin
        op = clt_pkg::CMD_VOTE;
        idx = snap_index_q + n_entries - 32'd1 + $urandom_range(0, 2);
      end else begin
        op = 3'($urandom_range(CMD_FIRST_BAD, CMD_LAST_BAD));
      end
      case ($urandom_range(0, 9))
        0: idx = $urandom;
        1: idx = snap_index_q - $urandom_range(0, 2);
        2: idx = '0;
        default: ;
      endcase
    end
    slot = idx - snap_index_q - 32'd1;
    case ($urandom_range(0, 9))
      0: term = $urandom;
      1, 2, 3, 4: ;
      default: begin
        if (op == clt_pkg::CMD_VOTE) term = log_tail_term();
        else if (slot < n_entries) term = term_mem[slot];
      end
    endcase
  endtask

  task automatic send_item(input logic [2:0] op, input logic [31:0] term,
                           input logic [31:0] idx, input bit typed,
                           input clt_pkg::res_t want);
    int unsigned   gap;
    clt_pkg::res_t model;
    gap = 0;
    if (!no_idle && $urandom_range(1, idle_odds) == 1) gap = $urandom_range(1, 18);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= op;
    term_in_i  <= term;
    index_in_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    model = table_step(op, term, idx);
    due_replies.insert(due_replies.size(), typed ? want : model);
  endtask

  task automatic run_mix(input int unsigned count);
    logic [2:0]  op;
    logic [31:0] term;
    logic [31:0] idx;
    repeat (count) begin
      pick_item(1'b0, op, term, idx);
      send_item(op, term, idx, 1'b0, '0);
    end
  endtask

  // Holds the input side off until every reply has been seen, then lets the pipeline empty.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input clt_pkg::cfg_idx_e which, input logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= which;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (which == clt_pkg::CFG_SNAP_INDEX) snap_index_q = value;
    else snap_term_q = value;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      if (n_errors < 10) $display("mismatch in %s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endtask

  initial begin : sink_pace
    @(posedge clk_i);
    forever begin
      if (!no_idle && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : reply_check
    clt_pkg::res_t got;
    clt_pkg::res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{status_o, index_out_o, term_out_o, ours_newer_o, last_index_o, last_term_o};
      if (due_replies.size() == 0) begin
        if (n_errors < 10) $display("reply with none outstanding: status %0d", got.status);
        n_errors++;
      end else begin
        want = due_replies.pop_front();
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("index_out", want.index_out, got.index_out);
        check_field("term_out", want.term_out, got.term_out);
        check_field("ours_newer", 32'(want.ours_newer), 32'(got.ours_newer));
        check_field("last_index", want.last_index, got.last_index);
        check_field("last_term", want.last_term, got.last_term);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : run
    logic [2:0]  op;
    logic [31:0] term;
    logic [31:0] idx;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].op, dir_rows[i].term, dir_rows[i].idx, dir_rows[i].typed,
                dir_rows[i].want);
    end

    settle();
    write_reg(clt_pkg::CFG_SNAP_INDEX, 32'd100);
    write_reg(clt_pkg::CFG_SNAP_TERM, 32'hFFFF_FFFF);
    run_mix(300);

    // Snapshot just below the top of the index range: appends run into the overflow.
    settle();
    write_reg(clt_pkg::CFG_SNAP_INDEX, 32'hFFFF_FFF0);
    write_reg(clt_pkg::CFG_SNAP_TERM, '0);
    send_item(clt_pkg::CMD_TRUNCATE, '0, 32'hFFFF_FFF1, 1'b0, '0);
    run_mix(200);

    settle();
    write_reg(clt_pkg::CFG_SNAP_INDEX, $urandom);
    write_reg(clt_pkg::CFG_SNAP_TERM, $urandom);
    run_mix(250);

    // Fill the store completely, then keep pushing against the full log.
    settle();
    write_reg(clt_pkg::CFG_SNAP_INDEX, $urandom_range(0, 1000));
    write_reg(clt_pkg::CFG_SNAP_TERM, 32'd5);
    idle_odds = 10;
    while (n_entries < LOG_DEPTH) begin
      pick_item(1'b1, op, term, idx);
      send_item(op, term, idx, 1'b0, '0);
    end
    idle_odds = 4;
    run_mix(40);

    // With the entries left from the fill behind the top snapshot index the last index must saturate.
    settle();
    write_reg(clt_pkg::CFG_SNAP_INDEX, 32'hFFFF_FFFF);
    write_reg(clt_pkg::CFG_SNAP_TERM, $urandom);
    run_mix(120);

    settle();
    write_reg(clt_pkg::CFG_SNAP_INDEX, '0);
    write_reg(clt_pkg::CFG_SNAP_TERM, '0);
    no_idle = 1'b1;
    run_mix(250);

    settle();
    if (n_errors == 0 && due_replies.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/clt_pkg.sv
src/clt_ram.sv
src/clt_ctrl.sv
src/consensus_log_term_table.sv
sim/tb_top.sv
